[rtl/assert_macros.svh]
// Assertion macros used by nntb_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NNTB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nntb assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NNTB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nntb assertion failed");

`endif

[rtl/nntb_pkg.sv]
package nntb_pkg;

   // Sizes of the distance matrix and its entries.
   localparam int MAX_TOWNS   = 64;
   localparam int DIST_BITS   = 32;
   localparam int TOWN_BITS   = $clog2(MAX_TOWNS);
   localparam int ADDR_BITS   = 2 * TOWN_BITS;
   localparam int STORE_DEPTH = MAX_TOWNS * MAX_TOWNS;
   localparam int CFG_BITS    = 7;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_START = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [TOWN_BITS-1:0] from_town;
      logic [TOWN_BITS-1:0] to_town;
      logic [DIST_BITS-1:0] distance_value;
      logic [TOWN_BITS-1:0] start_town;
   } nntb_req_type;

   typedef struct packed {
      logic [TOWN_BITS-1:0] tour_town;
      logic [TOWN_BITS-1:0] tour_position;
      logic                 last_of_tour;
   } nntb_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_wr;
      logic tour_init;
      logic scan_run;
      logic commit;
   } nntb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start_ok;
      logic single_town;
      logic scan_last;
      logic last_commit;
   } nntb_status_type;

endpackage

[rtl/nntb_datapath.sv]
module nntb_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  nntb_pkg::nntb_req_type  req_payload,
   input  logic                    csr_wr_en,
   input  logic [6:0]              csr_wr_data,
   input  nntb_pkg::nntb_cmd_type  cmd,
   output nntb_pkg::nntb_status_type status,
   output logic                    rsp_valid,
   output nntb_pkg::nntb_rsp_type  rsp_payload
);
   import nntb_pkg::*;

   // Distance matrix, row = from town, column = to town.
   logic [DIST_BITS-1:0] mem [STORE_DEPTH];
   logic [DIST_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr;

   logic [CFG_BITS-1:0]  num_towns_ff, num_towns_in;
   logic [CFG_BITS-1:0]  num_towns_dec;
   logic [TOWN_BITS-1:0] eff_m1;

   logic [TOWN_BITS-1:0] n_m1_ff, n_m1_in;
   logic [TOWN_BITS-1:0] cur_ff, cur_in;
   logic [TOWN_BITS-1:0] pos_ff, pos_in;
   logic [TOWN_BITS-1:0] pos_nxt;
   logic [TOWN_BITS-1:0] t_cnt_ff, t_cnt_in;
   logic [TOWN_BITS-1:0] t_d_ff, t_d_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [MAX_TOWNS-1:0] visited_ff, visited_in;
   logic                 have_ff, have_in;
   logic [DIST_BITS-1:0] best_ff, best_in;
   logic [TOWN_BITS-1:0] best_town_ff, best_town_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   nntb_rsp_type         rsp_ff, rsp_in;
   logic                 take;

   // Effective town count minus one, clamped to one through MAX_TOWNS.
   assign num_towns_dec = num_towns_ff - CFG_BITS'(1);
   always_comb begin
      if (num_towns_ff > CFG_BITS'(MAX_TOWNS)) begin
         eff_m1 = TOWN_BITS'(MAX_TOWNS - 1);
      end else if (num_towns_ff == '0) begin
         eff_m1 = '0;
      end else begin
         eff_m1 = num_towns_dec[TOWN_BITS-1:0];
      end
   end

   assign pos_nxt = pos_ff + TOWN_BITS'(1);
   assign rd_addr = {cur_ff, t_cnt_ff};

   assign status.start_ok    = (req_payload.start_town <= eff_m1);
   assign status.single_town = (eff_m1 == '0);
   assign status.scan_last   = (t_cnt_ff == n_m1_ff);
   assign status.last_commit = (pos_nxt == n_m1_ff);

   // A returned distance replaces the running best when its town is unvisited
   // and it is the first candidate or strictly smaller.
   assign take = rd_vld_ff && !visited_ff[t_d_ff] && (!have_ff || (rd_data_ff < best_ff));

   // Next-state logic of the datapath registers.
   always_comb begin
      num_towns_in = csr_wr_en ? csr_wr_data : num_towns_ff;
      n_m1_in      = n_m1_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      t_cnt_in     = cmd.scan_run ? t_cnt_ff + TOWN_BITS'(1) : t_cnt_ff;
      t_d_in       = t_cnt_ff;
      rd_vld_in    = cmd.scan_run;
      visited_in   = visited_ff;
      have_in      = have_ff | take;
      best_in      = take ? rd_data_ff : best_ff;
      best_town_in = take ? t_d_ff : best_town_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.tour_init) begin
         n_m1_in               = eff_m1;
         cur_in                = req_payload.start_town;
         pos_in                = '0;
         t_cnt_in              = '0;
         have_in               = 1'b0;
         visited_in            = '0;
         visited_in[req_payload.start_town] = 1'b1;
         rsp_valid_in          = 1'b1;
         rsp_in.tour_town      = req_payload.start_town;
         rsp_in.tour_position  = '0;
         rsp_in.last_of_tour   = (eff_m1 == '0);
      end else if (cmd.commit) begin
         cur_in                = best_town_ff;
         pos_in                = pos_nxt;
         t_cnt_in              = '0;
         have_in               = 1'b0;
         visited_in[best_town_ff] = 1'b1;
         rsp_valid_in          = 1'b1;
         rsp_in.tour_town      = best_town_ff;
         rsp_in.tour_position  = pos_nxt;
         rsp_in.last_of_tour   = (pos_nxt == n_m1_ff);
      end
   end

   // Matrix write port and registered read port.
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         mem[{req_payload.from_town, req_payload.to_town}] <= req_payload.distance_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_towns_ff <= CFG_BITS'(MAX_TOWNS);
         visited_ff   <= '0;
         cur_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_towns_ff <= num_towns_in;
         visited_ff   <= visited_in;
         cur_ff       <= cur_in;
         rd_vld_ff    <= rd_vld_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_m1_ff      <= n_m1_in;
      pos_ff       <= pos_in;
      t_cnt_ff     <= t_cnt_in;
      t_d_ff       <= t_d_in;
      best_ff      <= best_in;
      best_town_ff <= best_town_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/nntb_ctrl.sv]
module nntb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_kind,
   input  nntb_pkg::nntb_status_type status,
   output nntb_pkg::nntb_cmd_type    cmd,
   output logic                      busy
);
   import nntb_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Sequencing: one scan of the row per tour position, then a drain state
   // for the last read and a commit state that places the town.
   always_comb begin
      state_in      = state_ff;
      cmd.load_wr   = 1'b0;
      cmd.tour_init = 1'b0;
      cmd.scan_run  = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == REQ_LOAD)) begin
               cmd.load_wr = 1'b1;
            end else if (accept && (req_kind == REQ_START) && status.start_ok) begin
               cmd.tour_init = 1'b1;
               if (!status.single_town) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.last_commit ? ST_IDLE : ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/nearest_neighbour_tour_builder_top.sv]
// Channel   Handshake            Payload                  Notes
// request   start / busy         req_payload (nntb_req)   load or start
// result    rsp_valid strobe     rsp_payload (nntb_rsp)   one cycle, no stall
// config    csr_wr_en            csr_wr_data[6:0]         num_towns_used
//
// A load is written in the same cycle as its transfer and leaves busy low.
// A start over n towns shows position 0 in the cycle after the transfer, then one
// result per further position: the matrix row is scanned one entry per cycle
// through the single read port, followed by a drain state and a commit state.
// Busy is high until the last result (never for a one-town tour).
// Reset is synchronous; the distance matrix is not cleared.
module nearest_neighbour_tour_builder_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  nntb_pkg::nntb_req_type req_payload,
   output logic                   rsp_valid,
   output nntb_pkg::nntb_rsp_type rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [6:0]             csr_wr_data
);
   import nntb_pkg::*;

   nntb_cmd_type    cmd;
   nntb_status_type status;

   // Sequencer.
   nntb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_payload.req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Matrix store, scan and result registers.
   nntb_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/nntb_checker.sv]
`include "assert_macros.svh"

module nntb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input nntb_pkg::nntb_req_type req_payload,
   input logic                   rsp_valid,
   input nntb_pkg::nntb_rsp_type rsp_payload
);
   import nntb_pkg::*;

   logic load_xfer;
   logic start_xfer;
   logic rsp_last;
   logic rsp_later;

   assign load_xfer  = start && !busy && (req_payload.req_type == REQ_LOAD);
   assign start_xfer = start && !busy && (req_payload.req_type == REQ_START);
   assign rsp_last   = rsp_valid && rsp_payload.last_of_tour;
   assign rsp_later  = rsp_valid && (rsp_payload.tour_position != '0);

   // A tour only begins from a start transfer.
   `NNTB_ASSERT_IMP(a_busy_from_start, clock, reset, $rose(busy), $past(start_xfer))

   // A tour ends exactly with its flagged last result.
   `NNTB_ASSERT_IMP(a_end_flagged, clock, reset, $fell(busy), rsp_last)

   // Results other than the last arrive while the tour is still running.
   `NNTB_ASSERT_IMP(a_mid_busy, clock, reset, rsp_valid && !rsp_last, busy)

   // Later positions come only out of a running tour.
   `NNTB_ASSERT_IMP(a_pos_busy, clock, reset, rsp_later, $past(busy))

   // A load transfer never causes a result or a busy period.
   `NNTB_ASSERT_NXT(a_load_quiet, clock, reset, load_xfer, !busy && !rsp_valid)

endmodule

bind nearest_neighbour_tour_builder_top nntb_checker u_nntb_checker (.*);
